/* design/segmental_nearest_medoid_assign_core_assert.svh */
// Assertion macros for the segmental nearest-medoid assignment core.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef SEGMENTAL_NEAREST_MEDOID_ASSIGN_CORE_ASSERT_SVH
`define SEGMENTAL_NEAREST_MEDOID_ASSIGN_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SNMA_ASSERT_CLK(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
`define SNMA_ASSERT(lbl, prop, msg) \
    `SNMA_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`else
`define SNMA_ASSERT_CLK(lbl, ck, rn, prop, msg)
`define SNMA_ASSERT(lbl, prop, msg)
`endif
`endif

/* design/snma_pkg.sv */
// Shared types and constants for the segmental nearest-medoid assignment core.
// Depends on nothing.
package snma_pkg;

    localparam int DEF_MAX_MEDOIDS = 16;
    localparam int DEF_MAX_DIMS    = 64;
    localparam int DEF_COORD_WIDTH = 32;

    localparam int FIELD_LIMIT   = 16;
    localparam int CFG_W         = 5;
    localparam int MIDX_W        = 4;
    localparam int DIDX_W        = 6;
    localparam int IN_COORD_W    = 32;
    localparam int PID_W         = 32;
    localparam int COUNT_W       = 32;

    typedef enum logic [1:0] {
        CMD_LOAD_COORD = 2'd0,
        CMD_LOAD_PID   = 2'd1,
        CMD_POINT      = 2'd2,
        CMD_CLEAR      = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ACC,
        S_MUL,
        S_CMP,
        S_DONE
    } state_t;

endpackage

/* design/segmental_nearest_medoid_assign_core.sv */
// Top level of the segmental nearest-medoid assignment core.
// Depends on snma_pkg and segmental_nearest_medoid_assign_core_assert.svh.
//
//   channel   handshake               payload
//   in        in_valid / in_ready     cmd, medoid_index, dim_index, coord_value,
//                                     in_subspace, point_id, last_coord
//   out       out_valid / out_ready   cluster_index, cluster_members, was_medoid
//   config    cfg_write_en            cfg_write_data (medoid count)
//
// Load and clear requests pass through S_EXEC back to S_IDLE. A point coordinate reads the
// medoids in turn from the single read port of the coordinate memory, which feeds one
// subtract-accumulate unit. A last coordinate then scans the active medoids (shared multiply
// pair, then compare) and updates the count in S_DONE, which waits while the output register
// is still full. Reset clears control, masks, sums and counts, not memories or datapath regs.
`include "segmental_nearest_medoid_assign_core_assert.svh"

module segmental_nearest_medoid_assign_core
    import snma_pkg::*;
#(
    parameter int MAX_MEDOIDS = DEF_MAX_MEDOIDS,
    parameter int MAX_DIMS    = DEF_MAX_DIMS,
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [CFG_W-1:0]              cfg_write_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    cmd,
    input  logic [MIDX_W-1:0]             medoid_index,
    input  logic [DIDX_W-1:0]             dim_index,
    input  logic signed [IN_COORD_W-1:0]  coord_value,
    input  logic                          in_subspace,
    input  logic [PID_W-1:0]              point_id,
    input  logic                          last_coord,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [MIDX_W-1:0]             cluster_index,
    output logic [COUNT_W-1:0]            cluster_members,
    output logic                          was_medoid
);

    localparam int CW           = (COORD_WIDTH < IN_COORD_W) ? COORD_WIDTH : IN_COORD_W;
    localparam int ACTIVE_LIMIT = (MAX_MEDOIDS < FIELD_LIMIT) ? MAX_MEDOIDS : FIELD_LIMIT;
    localparam int M_W          = $clog2(MAX_MEDOIDS);
    localparam int CNT_W        = $clog2(MAX_MEDOIDS + 1);
    localparam int DIM_W        = $clog2(MAX_DIMS);
    localparam int DC_W         = $clog2(MAX_DIMS + 1);
    localparam int SUM_W        = CW + 1 + DIM_W;
    localparam int PROD_W       = SUM_W + DC_W;
    localparam int MEM_DEPTH    = MAX_MEDOIDS * MAX_DIMS;
    localparam int ADDR_W       = $clog2(MEM_DEPTH);

    state_t state_reg, state_next;

    logic [CFG_W-1:0]    medoid_count_reg;
    logic [MAX_DIMS-1:0] mask_reg     [MAX_MEDOIDS];
    logic [DC_W-1:0]     dim_cnt_reg  [MAX_MEDOIDS];
    logic [SUM_W-1:0]    sum_reg      [MAX_MEDOIDS];
    logic [COUNT_W-1:0]  count_reg    [MAX_MEDOIDS];
    logic [PID_W-1:0]    pid_mem_reg  [MAX_MEDOIDS];
    logic [CW-1:0]       coord_mem    [MEM_DEPTH];

    cmd_t                cmd_reg;
    logic [M_W-1:0]      mi_reg;
    logic                mi_ok_reg;
    logic [DIDX_W-1:0]   dim_reg;
    logic                dim_ok_reg;
    logic [CW-1:0]       x_reg;
    logic                insub_reg;
    logic [PID_W-1:0]    pid_reg;
    logic                last_reg;

    logic [CNT_W-1:0]    iss_reg;
    logic                iss_on_reg;
    logic                v1_reg;
    logic [M_W-1:0]      m1_reg;
    logic [CW-1:0]       rd_reg;
    logic                v2_reg;
    logic [M_W-1:0]      m2_reg;
    logic [CW:0]         diff_reg;

    logic [CNT_W-1:0]    idx_reg;
    logic                matched_reg;
    logic [M_W-1:0]      match_reg;
    logic                have_best_reg;
    logic [M_W-1:0]      best_reg;
    logic [SUM_W-1:0]    best_sum_reg;
    logic [DC_W-1:0]     best_cnt_reg;
    logic [PROD_W-1:0]   lhs_reg;
    logic [PROD_W-1:0]   rhs_reg;

    logic                out_valid_reg;
    logic [MIDX_W-1:0]   cluster_index_reg;
    logic [COUNT_W-1:0]  cluster_members_reg;
    logic                was_medoid_reg;

    logic [CNT_W-1:0]    n_active;
    logic [M_W-1:0]      sel;
    logic [M_W-1:0]      arr_idx;
    logic [DIM_W-1:0]    dsel;
    logic                scan_last;
    logic                acc_drained;
    logic                out_free;
    logic                mem_we;
    logic                mem_re;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   rd_addr;
    logic signed [CW:0]  diff_s;
    logic [CW:0]         diff_abs;
    logic [PROD_W-1:0]   lhs_next;
    logic [PROD_W-1:0]   rhs_next;

    assign n_active = (medoid_count_reg == '0) ? CNT_W'(1)
                    : ((int'(medoid_count_reg) > ACTIVE_LIMIT) ? CNT_W'(ACTIVE_LIMIT)
                    : CNT_W'(medoid_count_reg));
    assign sel         = matched_reg ? match_reg : best_reg;
    assign dsel        = dim_reg[DIM_W-1:0];
    assign scan_last   = (idx_reg + CNT_W'(1)) == n_active;
    assign acc_drained = !iss_on_reg && !v1_reg && !v2_reg;
    assign out_free    = !out_valid_reg || out_ready;
    assign wr_addr     = ADDR_W'(int'(mi_reg) * MAX_DIMS + int'(dsel));
    assign rd_addr     = ADDR_W'(int'(iss_reg[M_W-1:0]) * MAX_DIMS + int'(dsel));
    assign diff_s      = $signed({x_reg[CW-1], x_reg}) - $signed({rd_reg[CW-1], rd_reg});
    assign diff_abs    = diff_s[CW] ? (CW+1)'(-diff_s) : (CW+1)'(diff_s);
    assign lhs_next    = PROD_W'(sum_reg[arr_idx]) * PROD_W'(best_cnt_reg);
    assign rhs_next    = PROD_W'(best_sum_reg) * PROD_W'(dim_cnt_reg[arr_idx]);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd_reg != CMD_POINT)
                begin
                    state_next = S_IDLE;
                end
                else if (dim_ok_reg)
                begin
                    state_next = S_ACC;
                end
                else if (last_reg)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_ACC:
            begin
                if (acc_drained)
                begin
                    state_next = last_reg ? S_MUL : S_IDLE;
                end
            end
            S_MUL:
            begin
                if (dim_cnt_reg[arr_idx] != '0 && have_best_reg)
                begin
                    state_next = S_CMP;
                end
                else if (scan_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_CMP:
            begin
                state_next = scan_last ? S_DONE : S_MUL;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        arr_idx  = idx_reg[M_W-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_EXEC:
            begin
                arr_idx = mi_reg;
                mem_we  = (cmd_reg == CMD_LOAD_COORD) && mi_ok_reg && dim_ok_reg;
            end
            S_ACC:
            begin
                arr_idx = m2_reg;
                mem_re  = iss_on_reg;
            end
            S_DONE:
            begin
                arr_idx = sel;
            end
            default:
            begin
                arr_idx = idx_reg[M_W-1:0];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            coord_mem[wr_addr] <= x_reg;
        end
        if (mem_re)
        begin
            rd_reg <= coord_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EXEC && cmd_reg == CMD_LOAD_PID && mi_ok_reg)
        begin
            pid_mem_reg[mi_reg] <= pid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            medoid_count_reg <= CFG_W'(1);
            iss_reg          <= '0;
            iss_on_reg       <= 1'b0;
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            idx_reg          <= '0;
            matched_reg      <= 1'b0;
            have_best_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < MAX_MEDOIDS; i++)
            begin
                mask_reg[i]    <= '0;
                dim_cnt_reg[i] <= '0;
                sum_reg[i]     <= '0;
                count_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write_en)
            begin
                medoid_count_reg <= cfg_write_data;
            end
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_EXEC:
                begin
                    iss_reg       <= '0;
                    iss_on_reg    <= 1'b1;
                    v1_reg        <= 1'b0;
                    v2_reg        <= 1'b0;
                    idx_reg       <= '0;
                    matched_reg   <= 1'b0;
                    have_best_reg <= 1'b0;
                    if (cmd_reg == CMD_LOAD_COORD && mi_ok_reg && dim_ok_reg)
                    begin
                        mask_reg[arr_idx][dsel] <= insub_reg;
                        if (insub_reg && !mask_reg[arr_idx][dsel])
                        begin
                            dim_cnt_reg[arr_idx] <= dim_cnt_reg[arr_idx] + DC_W'(1);
                        end
                        else if (!insub_reg && mask_reg[arr_idx][dsel])
                        begin
                            dim_cnt_reg[arr_idx] <= dim_cnt_reg[arr_idx] - DC_W'(1);
                        end
                    end
                    if (cmd_reg == CMD_CLEAR)
                    begin
                        for (int i = 0; i < MAX_MEDOIDS; i++)
                        begin
                            count_reg[i] <= '0;
                        end
                    end
                end
                S_ACC:
                begin
                    if (iss_on_reg)
                    begin
                        if (int'(iss_reg) == MAX_MEDOIDS - 1)
                        begin
                            iss_on_reg <= 1'b0;
                        end
                        else
                        begin
                            iss_reg <= iss_reg + CNT_W'(1);
                        end
                    end
                    v1_reg <= iss_on_reg;
                    v2_reg <= v1_reg;
                    if (v2_reg && mask_reg[arr_idx][dsel])
                    begin
                        sum_reg[arr_idx] <= sum_reg[arr_idx] + SUM_W'(diff_reg);
                    end
                end
                S_MUL:
                begin
                    if (pid_mem_reg[arr_idx] == pid_reg)
                    begin
                        matched_reg <= 1'b1;
                    end
                    if (dim_cnt_reg[arr_idx] != '0 && !have_best_reg)
                    begin
                        have_best_reg <= 1'b1;
                    end
                    if (state_next == S_MUL)
                    begin
                        idx_reg <= idx_reg + CNT_W'(1);
                    end
                end
                S_CMP:
                begin
                    if (state_next == S_MUL)
                    begin
                        idx_reg <= idx_reg + CNT_W'(1);
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        count_reg[arr_idx] <= count_reg[arr_idx] + COUNT_W'(1);
                        for (int i = 0; i < MAX_MEDOIDS; i++)
                        begin
                            sum_reg[i] <= '0;
                        end
                    end
                end
                default:
                begin
                    v1_reg <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            cmd_reg    <= cmd_t'(cmd);
            mi_reg     <= M_W'(medoid_index);
            mi_ok_reg  <= int'(medoid_index) < MAX_MEDOIDS;
            dim_reg    <= dim_index;
            dim_ok_reg <= int'(dim_index) < MAX_DIMS;
            x_reg      <= coord_value[CW-1:0];
            insub_reg  <= in_subspace;
            pid_reg    <= point_id;
            last_reg   <= last_coord;
        end
        m1_reg   <= iss_reg[M_W-1:0];
        m2_reg   <= m1_reg;
        diff_reg <= diff_abs;
        unique case (state_reg)
            S_EXEC:
            begin
                best_reg <= '0;
            end
            S_MUL:
            begin
                if (pid_mem_reg[arr_idx] == pid_reg)
                begin
                    match_reg <= arr_idx;
                end
                if (dim_cnt_reg[arr_idx] != '0 && !have_best_reg)
                begin
                    best_reg     <= arr_idx;
                    best_sum_reg <= sum_reg[arr_idx];
                    best_cnt_reg <= dim_cnt_reg[arr_idx];
                end
                lhs_reg <= lhs_next;
                rhs_reg <= rhs_next;
            end
            S_CMP:
            begin
                if (lhs_reg < rhs_reg)
                begin
                    best_reg     <= arr_idx;
                    best_sum_reg <= sum_reg[arr_idx];
                    best_cnt_reg <= dim_cnt_reg[arr_idx];
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cluster_index_reg   <= MIDX_W'(sel);
                    cluster_members_reg <= count_reg[arr_idx] + COUNT_W'(1);
                    was_medoid_reg      <= matched_reg;
                end
            end
            default:
            begin
                best_reg <= best_reg;
            end
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign cluster_index   = cluster_index_reg;
    assign cluster_members = cluster_members_reg;
    assign was_medoid      = was_medoid_reg;

    `SNMA_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "accepted while busy")
    `SNMA_ASSERT(a_scan_in_range, (state_reg == S_MUL || state_reg == S_CMP) |-> idx_reg < n_active, "scan index past active medoids")
    `SNMA_ASSERT(a_best_in_range, (state_reg == S_CMP || state_reg == S_DONE) && have_best_reg |-> CNT_W'(best_reg) < n_active, "best medoid not active")
    `SNMA_ASSERT(a_result_from_done, $rose(out_valid_reg) |-> $past(state_reg == S_DONE), "result outside assignment step")

endmodule

/* bench/tb_segmental_nearest_medoid_assign_core.sv */
// Testbench for segmental_nearest_medoid_assign_core: directed and random requests with a
// cycle-free predictor of the nearest-medoid assignment, checked against every result.
// Depends on snma_pkg and the core RTL.
module tb_segmental_nearest_medoid_assign_core
    import snma_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_MEDOIDS     = DEF_MAX_MEDOIDS;
    localparam int N_DIMS        = DEF_MAX_DIMS;
    localparam int SETTLE_CYCLES = 100;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [MIDX_W-1:0]  cluster;
        logic [COUNT_W-1:0] size;
        logic               was_medoid;
    } assignment_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_write_en;
    logic [CFG_W-1:0]             cfg_write_data;
    logic                         in_valid;
    logic                         in_ready;
    logic [1:0]                   cmd;
    logic [MIDX_W-1:0]            medoid_index;
    logic [DIDX_W-1:0]            dim_index;
    logic signed [IN_COORD_W-1:0] coord_value;
    logic                         in_subspace;
    logic [PID_W-1:0]             point_id;
    logic                         last_coord;
    logic                         out_valid;
    logic                         out_ready;
    logic [MIDX_W-1:0]            cluster_index;
    logic [COUNT_W-1:0]           cluster_members;
    logic                         was_medoid;

    logic signed [IN_COORD_W-1:0] medoid_coord [N_MEDOIDS][N_DIMS];
    logic [N_DIMS-1:0]            dim_mask [N_MEDOIDS];
    logic [6:0]                   dim_count [N_MEDOIDS];
    logic [PID_W-1:0]             medoid_pid [N_MEDOIDS];
    logic [38:0]                  dist_sum [N_MEDOIDS];
    logic [COUNT_W-1:0]           member_count [N_MEDOIDS];
    logic [CFG_W-1:0]             medoid_count_cfg;

    assignment_t expected_assignments[$];
    int          mismatch_count;
    int          requests_sent;
    int          tx_idle_pct;
    int          rx_stall_pct;
    int          rx_hold_cycles;

    segmental_nearest_medoid_assign_core u_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #60_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic void predict_request(cmd_t c, logic [MIDX_W-1:0] mi,
                                            logic [DIDX_W-1:0] di,
                                            logic signed [IN_COORD_W-1:0] cv, logic sub,
                                            logic [PID_W-1:0] pid, logic last);
        logic signed [32:0] diff;
        logic [32:0]        mag;
        logic [63:0]        lhs;
        logic [63:0]        rhs;
        int                 m;
        int                 active;
        int                 best;
        bit                 matched;
        bit                 have_best;
        assignment_t        result;
        case (c)
            CMD_LOAD_COORD:
            begin
                medoid_coord[mi][di] = cv;
                dim_mask[mi][di] = sub;
                dim_count[mi] = 7'($countones(dim_mask[mi]));
            end
            CMD_LOAD_PID:
            begin
                medoid_pid[mi] = pid;
            end
            CMD_CLEAR:
            begin
                for (m = 0; m < N_MEDOIDS; m++)
                    member_count[m] = '0;
            end
            default:
            begin
                for (m = 0; m < N_MEDOIDS; m++)
                begin
                    if (dim_mask[m][di])
                    begin
                        diff = {cv[31], cv} - {medoid_coord[m][di][31], medoid_coord[m][di]};
                        mag = diff[32] ? 33'(-diff) : 33'(diff);
                        dist_sum[m] = dist_sum[m] + 39'(mag);
                    end
                end
                if (last)
                begin
                    if (medoid_count_cfg == 0)
                        active = 1;
                    else if (medoid_count_cfg > N_MEDOIDS)
                        active = N_MEDOIDS;
                    else
                        active = int'(medoid_count_cfg);
                    matched = 1'b0;
                    have_best = 1'b0;
                    best = 0;
                    for (m = 0; m < active; m++)
                    begin
                        if (medoid_pid[m] == pid)
                        begin
                            matched = 1'b1;
                            best = m;
                        end
                    end
                    if (!matched)
                    begin
                        for (m = 0; m < active; m++)
                        begin
                            if (dim_count[m] != 0)
                            begin
                                if (!have_best)
                                begin
                                    have_best = 1'b1;
                                    best = m;
                                end
                                else
                                begin
                                    lhs = 64'(dist_sum[m]) * 64'(dim_count[best]);
                                    rhs = 64'(dist_sum[best]) * 64'(dim_count[m]);
                                    if (lhs < rhs)
                                        best = m;
                                end
                            end
                        end
                    end
                    member_count[best] = member_count[best] + COUNT_W'(1);
                    result.cluster = 4'(best);
                    result.size = member_count[best];
                    result.was_medoid = matched;
                    expected_assignments.push_back(result);
                    for (m = 0; m < N_MEDOIDS; m++)
                        dist_sum[m] = '0;
                end
            end
        endcase
    endfunction

    task automatic send_request(cmd_t c, logic [MIDX_W-1:0] mi, logic [DIDX_W-1:0] di,
                                logic [IN_COORD_W-1:0] cv, logic sub, logic [PID_W-1:0] pid,
                                logic last);
        if (tx_idle_pct > 0)
        begin
            while ($urandom_range(99) < tx_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        cmd <= c;
        medoid_index <= mi;
        dim_index <= di;
        coord_value <= cv;
        in_subspace <= sub;
        point_id <= pid;
        last_coord <= last;
        do
            @(posedge clk);
        while (!in_ready);
        predict_request(c, mi, di, cv, sub, pid, last);
        requests_sent++;
    endtask

    task automatic wait_for_idle();
        in_valid <= 1'b0;
        while (expected_assignments.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_medoid_count(logic [CFG_W-1:0] value);
        cfg_write_en <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        medoid_count_cfg = value;
    endtask

    function automatic logic [IN_COORD_W-1:0] pick_coord();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom();
            default: return 32'($urandom_range(0, 2097152)) - 32'h0010_0000;
        endcase
    endfunction

    function automatic logic [DIDX_W-1:0] pick_dim();
        if ($urandom_range(99) < 80)
            return 6'($urandom_range(7));
        return 6'($urandom_range(63));
    endfunction

    task automatic send_coord_load();
        send_request(CMD_LOAD_COORD, 4'($urandom_range(15)), pick_dim(), pick_coord(),
                     $urandom_range(99) < 65, $urandom(), 1'($urandom_range(1)));
    endtask

    task automatic send_random_point();
        int               len;
        int               k;
        logic [PID_W-1:0] pid;
        len = $urandom_range(1, 6);
        for (k = 0; k < len; k++)
        begin
            if (k > 0 && $urandom_range(99) < 10)
            begin
                if ($urandom_range(1) == 0)
                    send_coord_load();
                else
                    send_request(CMD_CLEAR, 4'($urandom_range(15)), 6'($urandom_range(63)),
                                 $urandom(), 1'($urandom_range(1)), $urandom(),
                                 1'($urandom_range(1)));
            end
            if ($urandom_range(99) < 30)
                pid = medoid_pid[$urandom_range(N_MEDOIDS - 1)];
            else
                pid = $urandom();
            send_request(CMD_POINT, 4'($urandom_range(15)), pick_dim(), pick_coord(),
                         1'($urandom_range(1)), pid, k == len - 1);
        end
    endtask

    task automatic run_random_phase(int n_requests);
        int               first;
        int               r;
        logic [PID_W-1:0] pid;
        first = requests_sent;
        while (requests_sent - first < n_requests)
        begin
            r = $urandom_range(99);
            if (r < 55)
            begin
                send_random_point();
            end
            else if (r < 85)
            begin
                send_coord_load();
            end
            else if (r < 95)
            begin
                if ($urandom_range(1) == 0)
                    pid = $urandom();
                else
                    pid = medoid_pid[$urandom_range(N_MEDOIDS - 1)];
                send_request(CMD_LOAD_PID, 4'($urandom_range(15)), 6'($urandom_range(63)),
                             $urandom(), 1'($urandom_range(1)), pid, 1'($urandom_range(1)));
            end
            else
            begin
                send_request(CMD_CLEAR, 4'($urandom_range(15)), 6'($urandom_range(63)),
                             $urandom(), 1'($urandom_range(1)), $urandom(),
                             1'($urandom_range(1)));
            end
        end
    endtask

    task automatic test_pid_load();
        int               m;
        logic [PID_W-1:0] pid;
        for (m = 0; m < N_MEDOIDS; m++)
        begin
            if (m == 0)
                pid = '0;
            else if (m == 3 || m == 9)
                pid = 32'hFFFF_FFFF;
            else
                pid = $urandom();
            send_request(CMD_LOAD_PID, 4'(m), 6'($urandom_range(63)), $urandom(),
                         1'($urandom_range(1)), pid, 1'($urandom_range(1)));
        end
    endtask

    task automatic test_empty_subspace();
        send_request(CMD_POINT, 4'd0, 6'd7, 32'd1234, 1'b0, 32'h1234_5678, 1'b1);
        send_request(CMD_POINT, 4'd0, 6'd7, 32'd1234, 1'b0, 32'h0, 1'b1);
    endtask

    task automatic test_extreme_coords();
        send_request(CMD_LOAD_COORD, 4'd1, 6'd0, 32'h7FFF_FFFF, 1'b1, 32'h0, 1'b0);
        send_request(CMD_LOAD_COORD, 4'd2, 6'd63, 32'h8000_0000, 1'b1, 32'h0, 1'b0);
        send_request(CMD_LOAD_COORD, 4'd2, 6'd0, 32'h0, 1'b1, 32'h0, 1'b0);
        send_request(CMD_LOAD_COORD, 4'd1, 6'd63, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0);
        send_request(CMD_POINT, 4'd0, 6'd0, 32'h8000_0000, 1'b0, 32'h0BAD_0001, 1'b0);
        send_request(CMD_POINT, 4'd0, 6'd63, 32'h7FFF_FFFF, 1'b0, 32'h0BAD_0001, 1'b1);
    endtask

    task automatic test_ties();
        send_request(CMD_LOAD_COORD, 4'd4, 6'd10, 32'd100, 1'b1, 32'h0, 1'b0);
        send_request(CMD_LOAD_COORD, 4'd5, 6'd10, 32'd100, 1'b1, 32'h0, 1'b0);
        send_request(CMD_POINT, 4'd0, 6'd10, 32'd0, 1'b0, 32'h0BAD_0002, 1'b1);
    endtask

    task automatic test_medoid_match();
        send_request(CMD_POINT, 4'd0, 6'd0, 32'd0, 1'b0, 32'hFFFF_FFFF, 1'b1);
        wait_for_idle();
        set_medoid_count(5'd5);
        send_request(CMD_POINT, 4'd0, 6'd0, 32'd0, 1'b0, 32'hFFFF_FFFF, 1'b1);
        wait_for_idle();
        set_medoid_count(5'd16);
    endtask

    task automatic test_clear_counts();
        send_request(CMD_CLEAR, 4'd0, 6'd0, 32'd0, 1'b0, 32'h0, 1'b0);
        send_request(CMD_POINT, 4'd0, 6'd0, 32'd5, 1'b0, 32'h0BAD_0003, 1'b1);
    endtask

    task automatic test_output_backpressure();
        int k;
        wait_for_idle();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        rx_hold_cycles = 600;
        for (k = 0; k < 15; k++)
            send_request(CMD_POINT, 4'($urandom_range(15)), pick_dim(), pick_coord(), 1'b0,
                         $urandom(), 1'b1);
        wait_for_idle();
    endtask

    task automatic test_random_traffic();
        logic [CFG_W-1:0] settings [8];
        int               tx_modes [4];
        int               rx_modes [4];
        int               p;
        settings = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd17, 5'($urandom_range(31)), 5'd8, 5'd16};
        tx_modes = '{0, 81, 0, 29};
        rx_modes = '{0, 0, 81, 29};
        for (p = 0; p < 8; p++)
        begin
            wait_for_idle();
            set_medoid_count(settings[p]);
            tx_idle_pct = tx_modes[p % 4];
            rx_stall_pct = rx_modes[p % 4];
            run_random_phase(180);
        end
        wait_for_idle();
    endtask

    task automatic check_assignment();
        assignment_t want;
        if (expected_assignments.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("unexpected assignment: cluster %0d size %0d medoid %0b",
                         cluster_index, cluster_members, was_medoid);
            return;
        end
        want = expected_assignments.pop_front();
        if (cluster_index !== want.cluster || cluster_members !== want.size ||
            was_medoid !== want.was_medoid)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display({"assignment mismatch: expected cluster %0d size %0d medoid %0b,",
                          " got cluster %0d size %0d medoid %0b"},
                         want.cluster, want.size, want.was_medoid,
                         cluster_index, cluster_members, was_medoid);
        end
    endtask

    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                check_assignment();
            if (rx_hold_cycles > 0)
            begin
                rx_hold_cycles--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= $urandom_range(99) >= rx_stall_pct;
            end
        end
    end

    initial
    begin
        mismatch_count = 0;
        requests_sent = 0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        rx_hold_cycles = 0;
        medoid_count_cfg = 5'd1;
        for (int m = 0; m < N_MEDOIDS; m++)
        begin
            dim_mask[m] = '0;
            dim_count[m] = '0;
            medoid_pid[m] = '0;
            dist_sum[m] = '0;
            member_count[m] = '0;
        end
        rst_n <= 1'b0;
        cfg_write_en <= 1'b0;
        cfg_write_data <= '0;
        in_valid <= 1'b0;
        cmd <= CMD_LOAD_COORD;
        medoid_index <= '0;
        dim_index <= '0;
        coord_value <= '0;
        in_subspace <= 1'b0;
        point_id <= '0;
        last_coord <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_pid_load();
        test_empty_subspace();
        wait_for_idle();
        set_medoid_count(5'd16);
        test_extreme_coords();
        test_ties();
        test_medoid_match();
        test_clear_counts();
        test_output_backpressure();
        test_random_traffic();

        if (mismatch_count == 0 && expected_assignments.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/snma_pkg.sv
design/segmental_nearest_medoid_assign_core.sv
bench/tb_segmental_nearest_medoid_assign_core.sv
